FILE: rtl/core/bs3_pkg.sv
package bs3_pkg;

    localparam int SIZE_W      = 10;
    localparam int PIX_W       = 16;
    localparam int SUM_W       = 20;
    localparam int RECIP_W     = 25;
    localparam int RECIP_SHIFT = 24;
    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;

    // Word index of each register, taken from paddr[2].
    localparam logic [0:0] REG_IMAGE_SIZE = 1'b0;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } bs3_pix_t;

    typedef struct packed {
        bs3_pix_t upper;
        bs3_pix_t middle;
    } bs3_col_t;

    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] pix_red;
        logic [PIX_W-1:0] pix_green;
        logic [PIX_W-1:0] pix_blue;
    } bs3_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] avg_red;
        logic [PIX_W-1:0] avg_green;
        logic [PIX_W-1:0] avg_blue;
        logic             frame_last;
    } bs3_out_t;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } bs3_ctl_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } bs3_sum_t;

    // Reciprocal of the neighborhood size, scaled by 2**RECIP_SHIFT and rounded up.
    // The rounding error is small enough that the quotient is exact for any sum
    // below 2**SUM_W.
    function automatic logic [RECIP_W-1:0] recip_lut(input logic [1:0] rows,
                                                     input logic [1:0] cols);
        logic [RECIP_W-1:0] m;
        case ({rows, cols})
            4'b0101: m = 25'd16777216;
            4'b0110: m = 25'd8388608;
            4'b1001: m = 25'd8388608;
            4'b0111: m = 25'd5592406;
            4'b1101: m = 25'd5592406;
            4'b1010: m = 25'd4194304;
            4'b1011: m = 25'd2796203;
            4'b1110: m = 25'd2796203;
            4'b1111: m = 25'd1864136;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/core/bs3_line_buf.sv
module bs3_line_buf #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic              aclk,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  bs3_pkg::bs3_col_t wr_data,
    output bs3_pkg::bs3_col_t rd_data
);

    bs3_pkg::bs3_col_t mem [DEPTH];
    bs3_pkg::bs3_col_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_reg <= wr_data;
        end else begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

FILE: rtl/core/bs3_mean.sv
module bs3_mean (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    a_valid,
    input  bs3_pkg::bs3_ctl_t       a_ctl,
    input  bs3_pkg::bs3_pix_t [8:0] win,
    output logic                    a_ready,
    output logic                    m_valid,
    input  logic                    m_ready,
    output bs3_pkg::bs3_out_t       m_data
);

    localparam int PW = bs3_pkg::SUM_W + bs3_pkg::RECIP_W;

    logic                            b_valid_reg;
    bs3_pkg::bs3_sum_t               b_sum_reg;
    logic [bs3_pkg::RECIP_W-1:0]     b_recip_reg;
    logic                            b_last_reg;
    logic                            m_valid_reg;
    bs3_pkg::bs3_out_t               m_data_reg;

    logic                            c_free;
    logic                            b_free;
    logic [2:0]                      row_ok;
    logic [2:0]                      col_ok;
    logic [1:0]                      rows;
    logic [1:0]                      cols;
    bs3_pkg::bs3_sum_t               sum_next;
    logic [bs3_pkg::RECIP_W-1:0]     recip_next;
    logic [PW-1:0]                   prod_red;
    logic [PW-1:0]                   prod_green;
    logic [PW-1:0]                   prod_blue;

    assign c_free  = !m_valid_reg || m_ready;
    assign b_free  = !b_valid_reg || c_free;
    assign a_ready = b_free;

    assign row_ok = {a_ctl.bot_ok, 1'b1, a_ctl.top_ok};
    assign col_ok = {a_ctl.right_ok, 1'b1, a_ctl.left_ok};
    assign rows   = 2'd1 + {1'b0, a_ctl.top_ok} + {1'b0, a_ctl.bot_ok};
    assign cols   = 2'd1 + {1'b0, a_ctl.left_ok} + {1'b0, a_ctl.right_ok};
    assign recip_next = bs3_pkg::recip_lut(rows, cols);

    always_comb begin
        sum_next = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (row_ok[r] && col_ok[c]) begin
                    sum_next.red   = sum_next.red   + bs3_pkg::SUM_W'(win[r*3+c].red);
                    sum_next.green = sum_next.green + bs3_pkg::SUM_W'(win[r*3+c].green);
                    sum_next.blue  = sum_next.blue  + bs3_pkg::SUM_W'(win[r*3+c].blue);
                end
            end
        end
    end

    assign prod_red   = PW'(b_sum_reg.red)   * PW'(b_recip_reg);
    assign prod_green = PW'(b_sum_reg.green) * PW'(b_recip_reg);
    assign prod_blue  = PW'(b_sum_reg.blue)  * PW'(b_recip_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (b_free) begin
                b_valid_reg <= a_valid;
            end
            if (c_free) begin
                m_valid_reg <= b_valid_reg;
            end
        end
        if (b_free && a_valid) begin
            b_sum_reg   <= sum_next;
            b_recip_reg <= recip_next;
            b_last_reg  <= a_ctl.last;
        end
        if (c_free && b_valid_reg) begin
            m_data_reg.avg_red    <= prod_red[bs3_pkg::RECIP_SHIFT +: bs3_pkg::PIX_W];
            m_data_reg.avg_green  <= prod_green[bs3_pkg::RECIP_SHIFT +: bs3_pkg::PIX_W];
            m_data_reg.avg_blue   <= prod_blue[bs3_pkg::RECIP_SHIFT +: bs3_pkg::PIX_W];
            m_data_reg.frame_last <= b_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/box_smooth_3x3.sv
// Path: the item completing a neighborhood passes the window, sum and divide registers
// in turn, the last driving m_valid; each output lags its input by n+1 items, n being
// image_size clamped to 1..MAX_SIZE. Throughput: one item per cycle unless m_ready
// stalls, through the line store (it reads and writes in the same cycle) and each register.
// Reset: synchronous, active low; clears counters, window, pipeline and sets
// image_size to 512. Line stores are not cleared and need no clearing pass.
module box_smooth_3x3 #(
    parameter int MAX_SIZE = 512
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  bs3_pkg::bs3_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output bs3_pkg::bs3_out_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bs3_pkg::APB_AW-1:0]    paddr,
    input  logic [bs3_pkg::APB_DW-1:0]    pwdata,
    output logic [bs3_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int CW = $clog2(MAX_SIZE + 2);
    localparam int AW = $clog2(MAX_SIZE);
    localparam int EW = (CW > bs3_pkg::SIZE_W) ? CW : bs3_pkg::SIZE_W;

    logic [bs3_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [CW-1:0]              in_row_reg, in_row_next;
    logic [CW-1:0]              in_col_reg, in_col_next;
    logic [CW-1:0]              out_row_reg, out_row_next;
    logic [CW-1:0]              out_col_reg, out_col_next;
    bs3_pkg::bs3_pix_t [8:0]    win_reg, win_next;
    logic                       a_valid_reg, a_valid_next;
    bs3_pkg::bs3_ctl_t          a_ctl_reg, a_ctl_next;

    logic                       cfg_wr;
    logic [EW-1:0]              size_ext;
    logic [CW-1:0]              n;
    logic [CW-1:0]              n_m1;
    logic                       accept;
    logic                       mean_ready;
    logic                       emit;
    bs3_pkg::bs3_pix_t          newpix;
    bs3_pkg::bs3_pix_t          top_pix;
    bs3_pkg::bs3_pix_t          mid_pix;
    bs3_pkg::bs3_col_t          col_rd;
    bs3_pkg::bs3_col_t          col_wr;
    bs3_pkg::bs3_ctl_t          ctl;

    assign cfg_wr = psel && penable && pwrite && (paddr[2:2] == bs3_pkg::REG_IMAGE_SIZE);
    assign prdata = (paddr[2:2] == bs3_pkg::REG_IMAGE_SIZE) ?
                    bs3_pkg::APB_DW'(size_reg) : '0;
    assign pready = 1'b1;

    assign size_ext = EW'(size_reg);

    always_comb begin
        if (size_reg == '0) begin
            n = CW'(1);
        end else if (size_ext > EW'(MAX_SIZE)) begin
            n = CW'(MAX_SIZE);
        end else begin
            n = CW'(size_ext);
        end
    end

    assign n_m1 = n - CW'(1);

    assign s_ready = !a_valid_reg || mean_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        if (!s_data.func && (in_row_reg < n)) begin
            newpix = '{red: s_data.pix_red, green: s_data.pix_green, blue: s_data.pix_blue};
        end else begin
            newpix = '0;
        end
    end

    assign top_pix = col_rd.upper;
    assign mid_pix = col_rd.middle;
    assign col_wr  = '{upper: mid_pix, middle: newpix};

    assign emit = (in_row_reg >= CW'(2)) || ((in_row_reg == CW'(1)) && (in_col_reg != '0));

    assign ctl.top_ok   = (out_row_reg != '0);
    assign ctl.bot_ok   = (out_row_reg < n_m1);
    assign ctl.left_ok  = (out_col_reg != '0);
    assign ctl.right_ok = (out_col_reg < n_m1);
    assign ctl.last     = (out_row_reg >= n_m1) && (out_col_reg >= n_m1);

    always_comb begin
        size_next    = size_reg;
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        win_next     = win_reg;
        a_valid_next = a_valid_reg;
        a_ctl_next   = a_ctl_reg;
        if (a_valid_reg && mean_ready) begin
            a_valid_next = 1'b0;
        end
        if (cfg_wr) begin
            size_next    = pwdata[bs3_pkg::SIZE_W-1:0];
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end else if (accept) begin
            for (int r = 0; r < 3; r++) begin
                win_next[r*3]   = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[2] = top_pix;
            win_next[5] = mid_pix;
            win_next[8] = newpix;
            a_valid_next = emit;
            a_ctl_next   = ctl;
            if (in_col_reg >= n_m1) begin
                in_col_next = '0;
                in_row_next = in_row_reg + CW'(1);
            end else begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (emit) begin
                if (ctl.last) begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end else if (out_col_reg >= n_m1) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + CW'(1);
                end else begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg    <= bs3_pkg::SIZE_RESET;
            in_row_reg  <= '0;
            in_col_reg  <= '0;
            out_row_reg <= '0;
            out_col_reg <= '0;
            win_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_ctl_reg   <= '0;
        end else begin
            size_reg    <= size_next;
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            win_reg     <= win_next;
            a_valid_reg <= a_valid_next;
            a_ctl_reg   <= a_ctl_next;
        end
    end

    bs3_line_buf #(
        .DEPTH(MAX_SIZE),
        .AW   (AW)
    ) u_line_buf (
        .aclk   (aclk),
        .rd_addr(in_col_next[AW-1:0]),
        .wr_en  (accept && !cfg_wr),
        .wr_addr(in_col_reg[AW-1:0]),
        .wr_data(col_wr),
        .rd_data(col_rd)
    );

    bs3_mean u_mean (
        .aclk   (aclk),
        .aresetn(aresetn),
        .a_valid(a_valid_reg),
        .a_ctl  (a_ctl_reg),
        .win    (win_reg),
        .a_ready(mean_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

endmodule

FILE: rtl/core/bs3_checker.sv
module bs3_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input bs3_pkg::bs3_out_t             m_data,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [bs3_pkg::APB_AW-1:0]    paddr,
    input logic [bs3_pkg::APB_DW-1:0]    pwdata,
    input logic [bs3_pkg::APB_DW-1:0]    prdata,
    input logic                          pready
);

    logic size_wr;

    assign size_wr = psel && penable && pwrite && pready &&
                     (paddr[2:2] == bs3_pkg::REG_IMAGE_SIZE);

    // A stalled result keeps its value until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // The result channel is empty right after reset.
    a_out_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A write to image_size reads back in the next cycle.
    a_size_read: assert property (@(posedge aclk) disable iff (!aresetn)
        size_wr |=> (paddr[2:2] != bs3_pkg::REG_IMAGE_SIZE) ||
                    (prdata == bs3_pkg::APB_DW'($past(pwdata[bs3_pkg::SIZE_W-1:0]))))
        else $error("image_size readback mismatch");

    // After reset, image_size reads as its reset value.
    a_size_reset: assert property (@(posedge aclk)
        !aresetn |=> (paddr[2:2] != bs3_pkg::REG_IMAGE_SIZE) ||
                     (prdata == bs3_pkg::APB_DW'(bs3_pkg::SIZE_RESET)))
        else $error("image_size reset value mismatch");

endmodule

bind box_smooth_3x3 bs3_checker u_bs3_checker (.*);

FILE: tb/box_smooth_3x3_check.sv
`timescale 1ns / 100ps

module box_smooth_3x3_check (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  bs3_pkg::bs3_in_t           s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  bs3_pkg::bs3_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bs3_pkg::APB_AW-1:0] paddr,
    input  logic [bs3_pkg::APB_DW-1:0] pwdata,
    input  logic                       pready,
    output int                         means_due,
    output int                         mismatches
);

    localparam int LINE_DEPTH = 512;

    bs3_pkg::bs3_pix_t          upper_mem  [LINE_DEPTH];
    bs3_pkg::bs3_pix_t          middle_mem [LINE_DEPTH];
    bs3_pkg::bs3_pix_t          nbhd       [9];
    logic [bs3_pkg::SIZE_W-1:0] size_reg;
    int unsigned                in_r, in_c, out_r, out_c;
    bs3_pkg::bs3_out_t          pending_means [$];
    int                         fails = 0;

    function automatic int unsigned side_len();
        if (size_reg == '0) begin
            return 1;
        end
        if (32'(size_reg) > LINE_DEPTH) begin
            return LINE_DEPTH;
        end
        return 32'(size_reg);
    endfunction

    task automatic restart_frame();
        in_r  = 0;
        in_c  = 0;
        out_r = 0;
        out_c = 0;
    endtask

    task automatic clear_model();
        int k;
        for (k = 0; k < LINE_DEPTH; k++) begin
            upper_mem[k]  = '0;
            middle_mem[k] = '0;
        end
        for (k = 0; k < 9; k++) begin
            nbhd[k] = '0;
        end
        size_reg = bs3_pkg::SIZE_RESET;
        restart_frame();
        pending_means.delete();
    endtask

    // Shifts one item into the line stores and the 3x3 neighborhood, and
    // queues the mean of the pixel that this item completes, if any.
    task automatic smooth_pixel(input bs3_pkg::bs3_in_t d);
        int unsigned       n, c, i, j, r0, r1, c0, c1, sr, sg, sb, cnt;
        bs3_pkg::bs3_pix_t fresh, top_px, mid_px, p;
        logic              emit, last;
        bs3_pkg::bs3_out_t res;
        n     = side_len();
        c     = in_c;
        fresh = '0;
        if (!d.func && in_r < n) begin
            fresh = {d.pix_red, d.pix_green, d.pix_blue};
        end
        top_px        = upper_mem[c];
        mid_px        = middle_mem[c];
        upper_mem[c]  = mid_px;
        middle_mem[c] = fresh;
        for (i = 0; i < 3; i++) begin
            nbhd[i*3]   = nbhd[i*3+1];
            nbhd[i*3+1] = nbhd[i*3+2];
        end
        nbhd[2] = top_px;
        nbhd[5] = mid_px;
        nbhd[8] = fresh;

        emit = (in_r >= 2) || (in_r == 1 && in_c >= 1);
        in_c++;
        if (in_c >= n) begin
            in_c = 0;
            in_r++;
        end
        if (!emit) begin
            return;
        end

        r0 = (out_r > 0) ? 0 : 1;
        r1 = (out_r + 1 < n) ? 2 : 1;
        c0 = (out_c > 0) ? 0 : 1;
        c1 = (out_c + 1 < n) ? 2 : 1;
        sr = 0;
        sg = 0;
        sb = 0;
        for (i = r0; i <= r1; i++) begin
            for (j = c0; j <= c1; j++) begin
                p  = nbhd[i*3+j];
                sr += 32'(p.red);
                sg += 32'(p.green);
                sb += 32'(p.blue);
            end
        end
        cnt  = (r1 - r0 + 1) * (c1 - c0 + 1);
        last = (out_r + 1 >= n) && (out_c + 1 >= n);

        res.avg_red    = bs3_pkg::PIX_W'(sr / cnt);
        res.avg_green  = bs3_pkg::PIX_W'(sg / cnt);
        res.avg_blue   = bs3_pkg::PIX_W'(sb / cnt);
        res.frame_last = last;
        pending_means.push_back(res);

        if (last) begin
            restart_frame();
        end else begin
            out_c++;
            if (out_c >= n) begin
                out_c = 0;
                out_r++;
            end
        end
    endtask

    task automatic compare_field(input string name,
                                 input logic [bs3_pkg::PIX_W-1:0] want,
                                 input logic [bs3_pkg::PIX_W-1:0] got);
        if (got !== want) begin
            $error("%s expected %h got %h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_mean(input bs3_pkg::bs3_out_t got);
        bs3_pkg::bs3_out_t want;
        if (pending_means.size() == 0) begin
            $error("item out with no mean pending: %h", got);
            fails++;
        end else begin
            want = pending_means.pop_front();
            compare_field("avg_red", want.avg_red, got.avg_red);
            compare_field("avg_green", want.avg_green, got.avg_green);
            compare_field("avg_blue", want.avg_blue, got.avg_blue);
            compare_field("frame_last", bs3_pkg::PIX_W'(want.frame_last),
                          bs3_pkg::PIX_W'(got.frame_last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_model();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[2] == bs3_pkg::REG_IMAGE_SIZE) begin
                size_reg = pwdata[bs3_pkg::SIZE_W-1:0];
                restart_frame();
            end
            if (s_valid && s_ready) begin
                smooth_pixel(s_data);
            end
            if (m_valid && m_ready) begin
                check_mean(m_data);
            end
        end
        means_due  <= pending_means.size();
        mismatches <= fails;
    end

endmodule

FILE: tb/box_smooth_3x3_tb.sv
`timescale 1ns / 100ps

module box_smooth_3x3_tb;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int IDLE_PCT          = 23;
    localparam int HOLD_CYCLES       = 300;
    localparam int SETTLE_CYCLES     = 8;
    localparam int SMALL_FRAME_ITEMS = 400;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    bs3_pkg::bs3_in_t           s_data  = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    bs3_pkg::bs3_out_t          m_data;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [bs3_pkg::APB_AW-1:0] paddr   = '0;
    logic [bs3_pkg::APB_DW-1:0] pwdata  = '0;
    logic [bs3_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    int                         means_due;
    int                         mismatches;
    int                         cycles      = 0;
    int                         small_items = 0;
    logic                       calm        = 1'b0;
    logic                       hold_req    = 1'b0;

    box_smooth_3x3 u_top (.*);

    box_smooth_3x3_check u_check (.*);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver stalls at random, and holds off for a long stretch when asked.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic bs3_pkg::bs3_in_t mk(input logic f,
                                            input logic [bs3_pkg::PIX_W-1:0] r,
                                            input logic [bs3_pkg::PIX_W-1:0] g,
                                            input logic [bs3_pkg::PIX_W-1:0] b);
        return {f, r, g, b};
    endfunction

    function automatic bs3_pkg::bs3_in_t pixel(input logic f);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) begin
            return mk(f, '1, '1, '1);
        end else if (roll < 10) begin
            return mk(f, '0, '0, '0);
        end
        return mk(f, bs3_pkg::PIX_W'($urandom_range(65535)),
                  bs3_pkg::PIX_W'($urandom_range(65535)),
                  bs3_pkg::PIX_W'($urandom_range(65535)));
    endfunction

    task automatic offer(input bs3_pkg::bs3_in_t d);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (means_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_size(input logic [bs3_pkg::SIZE_W-1:0] value);
        logic [bs3_pkg::APB_DW-1:0] word;
        word                      = $urandom();
        word[bs3_pkg::SIZE_W-1:0] = value;
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {bs3_pkg::REG_IMAGE_SIZE, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends one frame of n x n pixels and its drain items, stopping early at cut.
    // With noise, flush items fall inside the frame and pixels inside the drain.
    task automatic stream_frame(input int unsigned n, input int unsigned noise,
                                input int unsigned cut);
        int unsigned k;
        logic        f;
        for (k = 0; k < n*n + n + 1 && k < cut; k++) begin
            if (k < n*n) begin
                f = ($urandom_range(99) < noise);
            end else begin
                f = !($urandom_range(99) < noise);
            end
            calm = (small_items >= 60 && small_items < 220);
            if (small_items == 260) begin
                hold_req = 1'b1;
            end
            if (small_items == 330) begin
                drain_results();
            end
            offer(pixel(f));
            small_items++;
        end
    endtask

    initial begin
        int unsigned roll, size_pick, n, frames, f, k;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // The reset size of 512 shows in when the first means come out.
        for (k = 0; k < 520; k++) begin
            offer(pixel(1'b0));
        end

        set_size('0);
        offer(mk(1'b0, '1, '1, '1));
        offer(mk(1'b0, 16'h1234, 16'h5678, 16'h9abc));
        offer(mk(1'b1, 16'hffff, 16'h0000, 16'hffff));

        set_size(bs3_pkg::SIZE_W'(2));
        offer(mk(1'b0, '1, '1, '1));
        offer(mk(1'b1, 16'hbeef, 16'hcafe, 16'h0001));
        offer(mk(1'b0, 16'h0000, 16'hffff, 16'h0001));
        offer(mk(1'b0, 16'h8000, 16'h7fff, 16'haaaa));
        offer(mk(1'b1, 16'h5555, 16'haaaa, 16'h5555));
        offer(mk(1'b0, '1, '1, '1));
        offer(mk(1'b1, 16'haaaa, 16'h5555, 16'haaaa));

        set_size(bs3_pkg::SIZE_W'(3));
        for (k = 0; k < 9; k++) begin
            offer(mk(1'b0, '1, '1, '1));
        end
        for (k = 0; k < 4; k++) begin
            offer(mk(1'b1, '0, '0, '0));
        end

        // An oversized setting acts as 512, so the first means come out as above.
        set_size('1);
        for (k = 0; k < 520; k++) begin
            offer(pixel(1'b0));
        end

        while (small_items < SMALL_FRAME_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                size_pick = 0;
            end else if (roll < 20) begin
                size_pick = $urandom_range(16, 9);
            end else begin
                size_pick = $urandom_range(8, 1);
            end
            set_size(bs3_pkg::SIZE_W'(size_pick));
            n      = (size_pick == 0) ? 1 : size_pick;
            frames = $urandom_range(3, 1);
            for (f = 0; f < frames; f++) begin
                roll = $urandom_range(99);
                if (roll < 70) begin
                    stream_frame(n, 0, 32'hffff_ffff);
                end else if (roll < 90) begin
                    stream_frame(n, 15, 32'hffff_ffff);
                end else begin
                    stream_frame(n, 15, $urandom_range(n*n + n, 1));
                    f = frames;
                end
            end
        end

        drain_results();
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
